// ----- rtl/crs_pkg.sv -----
// ----------------------------------------------------------------------------
// Call/return stack package
// Shared operation codes, fault codes and transaction types of the stack unit.
// ----------------------------------------------------------------------------
package crs_pkg;

   localparam int STACK_DEPTH_DEF = 256;
   localparam int WORD_W          = 32;
   localparam int IP_W            = 31;

   localparam logic [1:0] KIND_PUSH = 2'd0;
   localparam logic [1:0] KIND_POP  = 2'd1;
   localparam logic [1:0] KIND_CALL = 2'd2;
   localparam logic [1:0] KIND_RET  = 2'd3;

   localparam logic [2:0] FAULT_OK    = 3'd0;
   localparam logic [2:0] FAULT_CALL  = 3'd1;
   localparam logic [2:0] FAULT_EMPTY = 3'd2;
   localparam logic [2:0] FAULT_RET   = 3'd3;
   localparam logic [2:0] FAULT_FULL  = 3'd4;

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [WORD_W-1:0] operand_value;
      logic [IP_W-1:0]          current_ip;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped_value;
      logic [IP_W-1:0]          next_ip;
      logic [2:0]               fault;
   } rsp_type;

endpackage

// ----- rtl/crs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ----- rtl/crs_exec.sv -----
// ----------------------------------------------------------------------------
// Stack execution stage
// Holds the stack count and the top word in registers and the full stack in a
// RAM. The RAM is always read at the entry just below the next top, so a pop
// finds its new top word waiting in the read register.
// ----------------------------------------------------------------------------
module crs_exec import crs_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            op_valid,
   input  req_type         op_data,
   input  logic [IP_W-1:0] code_limit,
   output rsp_type         result
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [WORD_W-1:0] tos_ff;
   logic [WORD_W-1:0] tos_in;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] rd_data;
   logic [CW-1:0]     rd_index;
   logic              full;
   logic              empty;
   logic              operand_ok;
   logic              tos_ok;

   assign full       = (count_ff == CW'(STACK_DEPTH));
   assign empty      = (count_ff == '0);
   assign operand_ok = !op_data.operand_value[WORD_W-1]
                       && (op_data.operand_value[IP_W-1:0] < code_limit);
   assign tos_ok     = !tos_ff[WORD_W-1] && (tos_ff[IP_W-1:0] < code_limit);

   always_comb begin
      result.popped_value = '0;
      result.next_ip      = op_data.current_ip;
      result.fault        = FAULT_OK;
      count_in            = count_ff;
      tos_in              = tos_ff;
      wr_en               = 1'b0;
      wr_data             = op_data.operand_value;
      if (op_valid) begin
         case (op_data.kind)
            KIND_PUSH: begin
               if (full) begin
                  result.fault = FAULT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  tos_in   = op_data.operand_value;
                  count_in = count_ff + CW'(1);
               end
            end
            KIND_POP: begin
               if (empty) begin
                  result.fault = FAULT_EMPTY;
               end else begin
                  result.popped_value = tos_ff;
                  tos_in              = rd_data;
                  count_in            = count_ff - CW'(1);
               end
            end
            KIND_CALL: begin
               if (!operand_ok) begin
                  result.fault = FAULT_CALL;
               end else if (full) begin
                  result.fault = FAULT_FULL;
               end else begin
                  wr_en          = 1'b1;
                  wr_data        = {1'b0, op_data.current_ip};
                  tos_in         = {1'b0, op_data.current_ip};
                  count_in       = count_ff + CW'(1);
                  result.next_ip = op_data.operand_value[IP_W-1:0];
               end
            end
            KIND_RET: begin
               if (empty) begin
                  result.fault = FAULT_EMPTY;
               end else if (!tos_ok) begin
                  result.fault = FAULT_RET;
               end else begin
                  tos_in         = rd_data;
                  count_in       = count_ff - CW'(1);
                  result.next_ip = tos_ff[IP_W-1:0];
               end
            end
            default: begin
               result.fault = FAULT_OK;
            end
         endcase
      end
   end

   assign rd_index = count_in - CW'(2);

   crs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock      (clock),
      .write_en   (wr_en),
      .write_addr (count_ff[AW-1:0]),
      .write_data (wr_data),
      .read_addr  (rd_index[AW-1:0]),
      .read_data  (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
   end

endmodule

// ----- rtl/call_return_stack_unit.sv -----
// ----------------------------------------------------------------------------
// Call/return stack unit
// Push, pop, call and return on a word stack of STACK_DEPTH entries.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge with start high and busy low; busy
// is never raised, so one transaction can be accepted in every cycle. The
// request is captured in an input register, executed against the stack in the
// following cycle and its result is captured in the output register that
// drives rsp_strobe and rsp_data. The strobe stays high for one cycle per
// transaction. Exactly one result follows each transaction, in order. The
// receiver cannot stall the result channel. The stack words live in a RAM
// with a registered read port; the top word and the count are kept in
// registers, so a transaction never waits on a RAM read. The user must write
// the code limit through csr_write_en and csr_write_data only while no
// transaction is in flight; the block itself does not enforce this. Reset
// empties the stack and clears the code limit; no clearing pass is needed.
// ----------------------------------------------------------------------------
module call_return_stack_unit import crs_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_type         req_data,
   output logic            rsp_strobe,
   output rsp_type         rsp_data,
   input  logic            csr_write_en,
   input  logic [IP_W-1:0] csr_write_data
);

   logic            req_valid_ff;
   req_type         req_data_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;
   rsp_type         exec_result;
   logic [IP_W-1:0] code_limit_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         code_limit_ff <= '0;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
         if (csr_write_en) begin
            code_limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data;
      rsp_data_ff <= exec_result;
   end

   crs_exec #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (req_valid_ff),
      .op_data    (req_data_ff),
      .code_limit (code_limit_ff),
      .result     (exec_result)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_strobe)
      else $error("Executed transaction produced no result.");

   a_fault_keeps_ip: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && (exec_result.fault != FAULT_OK)
      |=> (rsp_data.next_ip == $past(req_data_ff.current_ip))
          && (rsp_data.popped_value == '0))
      else $error("Faulted transaction changed the pointer or popped a word.");

   a_pop_only_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.popped_value != '0)
      |-> (rsp_data.fault == FAULT_OK) && ($past(req_data_ff.kind) == KIND_POP))
      else $error("Popped value reported outside a successful pop.");

endmodule
